[hw/rtl/vpt_pkg.sv]
// Package of the video port and line timer: widths, port codes, command and
// state types, and the line timing table of the display modes.
// Used by the other files of the block but vpt_ram and vpt_checker; it depends on nothing.
package vpt_pkg;

  localparam int ModeW     = 3;
  localparam int ByteW     = 8;
  localparam int AddrW     = 14;
  localparam int VramDepth = 16384;
  localparam int LineW     = 9;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [ModeW-1:0] MODE_DATA_RD = 3'd0;
  localparam logic [ModeW-1:0] MODE_DATA_WR = 3'd1;
  localparam logic [ModeW-1:0] MODE_CTRL_WR = 3'd2;
  localparam logic [ModeW-1:0] MODE_STATUS  = 3'd3;
  localparam logic [ModeW-1:0] MODE_TICK    = 3'd4;

  localparam logic [1:0] CODE_READ   = 2'd0;
  localparam logic [1:0] CODE_REG    = 2'd2;
  localparam logic [1:0] CODE_COLOUR = 2'd3;

  localparam logic [3:0] REG_CTRL0 = 4'd0;
  localparam logic [3:0] REG_CTRL1 = 4'd1;
  localparam logic [3:0] REG_LINE  = 4'd10;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DATA_RD,
    OP_DATA_WR,
    OP_CTRL,
    OP_STATUS,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH
  } state_e;

  typedef enum logic [2:0] {
    KIND_M2,
    KIND_192,
    KIND_224,
    KIND_240,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0]            active;
    logic [LineW-1:0]            total;
    logic [2:0][ByteW-1:0]       first;
    logic [2:0][LineW-1:0]       len;
  } timing_t;

  function automatic kind_e timing_kind(logic [ByteW-1:0] reg0, logic [ByteW-1:0] reg1);
    logic [3:0] m;
    kind_e      k;
    m = {reg0[2], reg1[3], reg0[1], reg1[4]};
    unique case (m) inside
      4'h2:                   k = KIND_M2;
      4'h8, 4'ha, 4'hc, 4'hf: k = KIND_192;
      4'hb:                   k = KIND_224;
      4'he:                   k = KIND_240;
      default:                k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Range lengths are stored as last minus first plus one.
  function automatic timing_t timing_of(logic std, kind_e kind);
    timing_t t;
    t.total = std ? 9'd313 : 9'd262;
    t.first = '0;
    t.len   = {9'd1, 9'd1, 9'd1};
    unique case (kind)
      KIND_192: begin
        t.active = 8'd192;
        if (std) begin
          t.first[1] = 8'hba;
          t.len      = {9'd1, 9'd70, 9'd243};
        end else begin
          t.first[1] = 8'hd5;
          t.len      = {9'd1, 9'd43, 9'd219};
        end
      end
      KIND_224: begin
        t.active = 8'd224;
        if (std) begin
          t.first[2] = 8'hca;
          t.len      = {9'd54, 9'd3, 9'd256};
        end else begin
          t.first[1] = 8'he5;
          t.len      = {9'd1, 9'd27, 9'd235};
        end
      end
      KIND_240: begin
        t.active = 8'd240;
        if (std) begin
          t.first[2] = 8'hd2;
          t.len      = {9'd46, 9'd11, 9'd256};
        end else begin
          t.len      = {9'd1, 9'd7, 9'd256};
        end
      end
      default: begin
        t.active = 8'd192;
      end
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/vpt_if.sv]
// Channel interfaces of the video port and line timer: input items, result
// items and configuration writes. Depends on vpt_pkg for the field widths.
interface vpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [vpt_pkg::ModeW-1:0] mode;
  logic [vpt_pkg::ByteW-1:0] write_byte;
  modport source (output valid, mode, write_byte, input ready);
  modport sink (input valid, mode, write_byte, output ready);
endinterface

interface vpt_out_if;
  logic                      valid;
  logic                      ready;
  logic [vpt_pkg::ByteW-1:0] read_byte;
  logic                      interrupt_request;
  logic [vpt_pkg::ByteW-1:0] vertical_count;
  modport source (output valid, read_byte, interrupt_request, vertical_count, input ready);
  modport sink (input valid, read_byte, interrupt_request, vertical_count, output ready);
endinterface

interface vpt_cfg_if;
  logic valid;
  logic ready;
  logic video_standard;
  modport source (output valid, video_standard, input ready);
  modport sink (input valid, video_standard, output ready);
endinterface

[hw/rtl/video_port_and_line_timer_top.sv]
// Top level of the video port and line timer: front decoder and queue, back
// execution unit with video memory. Depends on vpt_pkg, vpt_if, vpt_front
// and vpt_back.
//
// Every accepted item gives one result beat. After reset the block clears its
// 16384-byte video memory, one byte a cycle, and holds the input not ready
// until the clear ends; configuration writes are taken at any time. The back
// unit executes an item in its idle state; a data read or a control write
// that starts a prefetch then passes through the fetch state, since the video
// memory read port is registered. A two-entry queue sits between decode and
// execution, and an output register holds a finished beat until it is taken.
module video_port_and_line_timer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpt_in_if.sink     in_i,
  vpt_out_if.source  out_o,
  vpt_cfg_if.sink    cfg_i
);

  logic          cmd_valid;
  vpt_pkg::cmd_t cmd;
  logic          cmd_pop;
  logic          clearing;

  vpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .clearing_i (clearing),
    .cmd_pop_i  (cmd_pop),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  vpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .out_o      (out_o),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .clearing_o (clearing)
  );

endmodule

[hw/rtl/vpt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; it depends on no package.
module vpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/vpt_front.sv]
// Front part: accepts input beats, decodes the mode into a command and keeps
// them in a short queue for the back part. Depends on vpt_pkg and vpt_if.
module vpt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpt_in_if.sink          in_i,
  input  logic            clearing_i,
  input  logic            cmd_pop_i,
  output logic            cmd_valid_o,
  output vpt_pkg::cmd_t   cmd_o
);

  vpt_pkg::cmd_t                     queue_q [vpt_pkg::QueueDepth];
  logic [vpt_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [vpt_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [vpt_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                              push;
  logic                              pop;
  vpt_pkg::cmd_t                     cmd_new;

  always_comb begin
    cmd_new.data = in_i.write_byte;
    unique case (in_i.mode)
      vpt_pkg::MODE_DATA_RD: cmd_new.op = vpt_pkg::OP_DATA_RD;
      vpt_pkg::MODE_DATA_WR: cmd_new.op = vpt_pkg::OP_DATA_WR;
      vpt_pkg::MODE_CTRL_WR: cmd_new.op = vpt_pkg::OP_CTRL;
      vpt_pkg::MODE_STATUS:  cmd_new.op = vpt_pkg::OP_STATUS;
      vpt_pkg::MODE_TICK:    cmd_new.op = vpt_pkg::OP_TICK;
      default:               cmd_new.op = vpt_pkg::OP_NONE;
    endcase
  end

  assign in_i.ready  = (count_q != vpt_pkg::QueueCntW'(vpt_pkg::QueueDepth)) && !clearing_i;
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[hw/rtl/vpt_back.sv]
// Back part: executes port commands and scanline ticks against the port
// state and video memory, and holds the result beat. Depends on vpt_pkg,
// vpt_if and vpt_ram.
module vpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpt_cfg_if.sink         cfg_i,
  vpt_out_if.source       out_o,
  input  logic            cmd_valid_i,
  input  vpt_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  output logic            clearing_o
);

  localparam logic [vpt_pkg::AddrW-1:0] VramLast = vpt_pkg::AddrW'(vpt_pkg::VramDepth - 1);

  vpt_pkg::state_e              state_q, state_d;
  logic [vpt_pkg::AddrW-1:0]    clr_cnt_q, clr_cnt_d;
  logic                         std_q;
  logic [vpt_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [1:0]                   code_q, code_d;
  logic [vpt_pkg::ByteW-1:0]    prefetch_q, prefetch_d;
  logic                         frame_q, frame_d;
  logic                         lflag_q, lflag_d;
  logic [vpt_pkg::ByteW-1:0]    lcnt_q, lcnt_d;
  logic                         pending_q, pending_d;
  logic [vpt_pkg::LineW-1:0]    scan_q, scan_d;
  logic [vpt_pkg::ByteW-1:0]    vcnt_q, vcnt_d;
  logic [vpt_pkg::ByteW-1:0]    reg0_q, reg0_d;
  logic [vpt_pkg::ByteW-1:0]    reg1_q, reg1_d;
  logic [vpt_pkg::ByteW-1:0]    reg10_q, reg10_d;
  logic                         out_valid_q, out_valid_d;
  logic [vpt_pkg::ByteW-1:0]    out_rd_q, out_rd_d;
  logic                         out_irq_q, out_irq_d;
  logic [vpt_pkg::ByteW-1:0]    out_vc_q, out_vc_d;

  logic                         take;
  logic                         fetch_needed;
  logic [vpt_pkg::ByteW-1:0]    rd_val;
  logic                         ram_we;
  logic [vpt_pkg::AddrW-1:0]    ram_waddr;
  logic [vpt_pkg::ByteW-1:0]    ram_wdata;
  logic [vpt_pkg::AddrW-1:0]    ram_raddr;
  logic [vpt_pkg::ByteW-1:0]    ram_rdata;
  logic [vpt_pkg::AddrW-1:0]    ctrl_addr;

  vpt_pkg::kind_e               kind;
  vpt_pkg::timing_t             tm;
  logic [vpt_pkg::LineW-1:0]    act_p1;
  logic [vpt_pkg::LineW:0]      line_inc;
  logic [vpt_pkg::LineW-1:0]    new_line;
  logic [vpt_pkg::LineW-1:0]    rem1, rem2;

  assign clearing_o = (state_q == vpt_pkg::ST_CLEAR);
  assign take       = (state_q == vpt_pkg::ST_IDLE) && cmd_valid_i &&
                      (!out_valid_q || out_o.ready);
  assign cmd_pop_o  = take;
  assign ctrl_addr  = {cmd_i.data[5:0], addr_q[7:0]};
  assign fetch_needed = (cmd_i.op == vpt_pkg::OP_DATA_RD) ||
                        ((cmd_i.op == vpt_pkg::OP_CTRL) && pending_q &&
                         (cmd_i.data[7:6] == vpt_pkg::CODE_READ));

  assign cfg_i.ready = 1'b1;

  assign ram_we    = clearing_o || (take && (cmd_i.op == vpt_pkg::OP_DATA_WR) &&
                                    (code_q != vpt_pkg::CODE_COLOUR));
  assign ram_waddr = clearing_o ? clr_cnt_q : addr_q;
  assign ram_wdata = clearing_o ? '0 : cmd_i.data;
  assign ram_raddr = (cmd_i.op == vpt_pkg::OP_CTRL) ? ctrl_addr : addr_q;

  vpt_ram #(
    .Width(vpt_pkg::ByteW),
    .Depth(vpt_pkg::VramDepth)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vpt_pkg::ST_CLEAR: begin
        if (clr_cnt_q == VramLast) state_d = vpt_pkg::ST_IDLE;
      end
      vpt_pkg::ST_IDLE: begin
        if (take && fetch_needed) state_d = vpt_pkg::ST_FETCH;
      end
      vpt_pkg::ST_FETCH: begin
        state_d = vpt_pkg::ST_IDLE;
      end
      default: begin
        state_d = vpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    kind     = vpt_pkg::timing_kind(reg0_q, reg1_q);
    tm       = vpt_pkg::timing_of(std_q, kind);
    act_p1   = {1'b0, tm.active} + 9'd1;
    line_inc = {1'b0, scan_q} + 10'd1;
    if (line_inc >= {1'b0, tm.total}) begin
      line_inc = line_inc - {1'b0, tm.total};
    end
    new_line = line_inc[vpt_pkg::LineW-1:0];
    rem1     = new_line - tm.len[0];
    rem2     = rem1 - tm.len[1];
  end

  always_comb begin
    clr_cnt_d  = clearing_o ? clr_cnt_q + 1'b1 : clr_cnt_q;
    addr_d     = addr_q;
    code_d     = code_q;
    prefetch_d = (state_q == vpt_pkg::ST_FETCH) ? ram_rdata : prefetch_q;
    frame_d    = frame_q;
    lflag_d    = lflag_q;
    lcnt_d     = lcnt_q;
    pending_d  = pending_q;
    scan_d     = scan_q;
    vcnt_d     = vcnt_q;
    reg0_d     = reg0_q;
    reg1_d     = reg1_q;
    reg10_d    = reg10_q;
    rd_val     = '0;
    if (take) begin
      unique case (cmd_i.op)
        vpt_pkg::OP_DATA_RD: begin
          pending_d = 1'b0;
          rd_val    = prefetch_q;
          addr_d    = addr_q + 1'b1;
        end
        vpt_pkg::OP_DATA_WR: begin
          pending_d = 1'b0;
          addr_d    = addr_q + 1'b1;
        end
        vpt_pkg::OP_CTRL: begin
          if (!pending_q) begin
            pending_d = 1'b1;
            addr_d    = {addr_q[13:8], cmd_i.data};
          end else begin
            pending_d = 1'b0;
            addr_d    = ctrl_addr;
            code_d    = cmd_i.data[7:6];
            if (cmd_i.data[7:6] == vpt_pkg::CODE_READ) begin
              addr_d = ctrl_addr + 1'b1;
            end else if (cmd_i.data[7:6] == vpt_pkg::CODE_REG) begin
              unique case (cmd_i.data[3:0])
                vpt_pkg::REG_CTRL0: reg0_d  = addr_q[7:0];
                vpt_pkg::REG_CTRL1: reg1_d  = addr_q[7:0];
                vpt_pkg::REG_LINE:  reg10_d = addr_q[7:0];
                default: ;
              endcase
            end
          end
        end
        vpt_pkg::OP_STATUS: begin
          pending_d = 1'b0;
          rd_val    = {frame_q, 7'b0};
          frame_d   = 1'b0;
          lflag_d   = 1'b0;
        end
        vpt_pkg::OP_TICK: begin
          if (kind != vpt_pkg::KIND_NONE) begin
            if (scan_q == act_p1) frame_d = 1'b1;
            if (scan_q <= {1'b0, tm.active}) begin
              if (lcnt_q == '0) begin
                lcnt_d  = reg10_q;
                lflag_d = 1'b1;
              end else begin
                lcnt_d = lcnt_q - 1'b1;
              end
            end else begin
              lcnt_d = reg10_q;
            end
            scan_d = new_line;
            if (new_line < tm.len[0]) begin
              vcnt_d = new_line[7:0] + tm.first[0];
            end else if (rem1 < tm.len[1]) begin
              vcnt_d = rem1[7:0] + tm.first[1];
            end else if (rem2 < tm.len[2]) begin
              vcnt_d = rem2[7:0] + tm.first[2];
            end
          end
        end
        default: ;
      endcase
    end
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_irq_d   = out_irq_q;
    out_vc_d    = out_vc_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_rd_d    = rd_val;
      out_irq_d   = (reg1_d[5] && frame_d) || (reg0_d[4] && lflag_d);
      out_vc_d    = vcnt_d;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpt_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      std_q       <= 1'b0;
      addr_q      <= '0;
      code_q      <= '0;
      prefetch_q  <= '0;
      frame_q     <= 1'b0;
      lflag_q     <= 1'b0;
      lcnt_q      <= '0;
      pending_q   <= 1'b0;
      scan_q      <= '0;
      vcnt_q      <= '0;
      reg0_q      <= '0;
      reg1_q      <= '0;
      reg10_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      if (cfg_i.valid) begin
        std_q <= cfg_i.video_standard;
      end
      addr_q      <= addr_d;
      code_q      <= code_d;
      prefetch_q  <= prefetch_d;
      frame_q     <= frame_d;
      lflag_q     <= lflag_d;
      lcnt_q      <= lcnt_d;
      pending_q   <= pending_d;
      scan_q      <= scan_d;
      vcnt_q      <= vcnt_d;
      reg0_q      <= reg0_d;
      reg1_q      <= reg1_d;
      reg10_q     <= reg10_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rd_q  <= out_rd_d;
    out_irq_q <= out_irq_d;
    out_vc_q  <= out_vc_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.read_byte         = out_rd_q;
  assign out_o.interrupt_request = out_irq_q;
  assign out_o.vertical_count    = out_vc_q;

endmodule

[hw/rtl/vpt_checker.sv]
// Port checker of the video port and line timer, bound to the top level.
// Depends only on the top level's ports.
module vpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_byte_i,
  input logic       interrupt_request_i,
  input logic [7:0] vertical_count_i
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] outst_q, outst_d;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    outst_d = outst_q;
    if (in_beat && !out_beat) begin
      outst_d = outst_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      outst_d = outst_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk_i) !rst_ni |=> !in_ready_i)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_byte_i) &&
      $stable(interrupt_request_i) && $stable(vertical_count_i))
    else $error("stalled result beat changed");

  a_no_extra_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> outst_q != 3'd0)
    else $error("result beat without an accepted item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 3'd3)
    else $error("more items in flight than the block can hold");

endmodule

bind video_port_and_line_timer_top vpt_checker u_vpt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .read_byte_i        (out_o.read_byte),
  .interrupt_request_i(out_o.interrupt_request),
  .vertical_count_i   (out_o.vertical_count)
);

[tb/vpt_result_checker.sv]
// Result checker of the video port and line timer: watches the input, result
// and configuration channels, predicts each result beat and compares it.
// Depends on vpt_pkg and on the channel interfaces of vpt_if.
module vpt_result_checker
  import vpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  vpt_in_if    in_i,
  vpt_out_if   out_i,
  vpt_cfg_if   cfg_i,
  output int   errors_o,
  output int   due_o,
  output int   line_o
);

  typedef struct packed {
    logic [ByteW-1:0] read_byte;
    logic             irq;
    logic [ByteW-1:0] vcount;
  } beat_t;

  logic [ByteW-1:0] vram [VramDepth];
  logic [ByteW-1:0] cram [32];
  logic [ByteW-1:0] regs [11];
  logic [AddrW-1:0] addr;
  logic [1:0]       code;
  logic [ByteW-1:0] prefetch;
  logic [ByteW-1:0] status;
  logic             line_flag;
  logic [ByteW-1:0] line_ctr;
  logic             second_byte;
  logic [LineW-1:0] scan;
  logic [ByteW-1:0] vcount;
  logic             std50;
  beat_t            beats_due [$];
  int               errors;

  function automatic kind_e kind_of();
    logic [3:0] m;
    m = {regs[REG_CTRL0][2], regs[REG_CTRL1][3], regs[REG_CTRL0][1], regs[REG_CTRL1][4]};
    if (m == 4'h2) return KIND_M2;
    if (m == 4'h8 || m == 4'ha || m == 4'hc || m == 4'hf) return KIND_192;
    if (m == 4'hb) return KIND_224;
    if (m == 4'he) return KIND_240;
    return KIND_NONE;
  endfunction

  // The new line walks through up to three ranges of counter values; -1 means
  // the line lies beyond them and the counter keeps its value.
  function automatic int map_line(input logic s, input kind_e k, input int line);
    int lo [3];
    int hi [3];
    int n;
    lo = '{0, 0, 0};
    hi = '{0, 0, 0};
    n  = line;
    case (k)
      KIND_192: begin
        if (s) begin
          lo = '{0, 'hba, 0};
          hi = '{'hf2, 'hff, 0};
        end else begin
          lo = '{0, 'hd5, 0};
          hi = '{'hda, 'hff, 0};
        end
      end
      KIND_224: begin
        if (s) begin
          lo = '{0, 0, 'hca};
          hi = '{'hff, 'h02, 'hff};
        end else begin
          lo = '{0, 'he5, 0};
          hi = '{'hea, 'hff, 0};
        end
      end
      KIND_240: begin
        if (s) begin
          lo = '{0, 0, 'hd2};
          hi = '{'hff, 'h0a, 'hff};
        end else begin
          hi = '{'hff, 'h06, 0};
        end
      end
      default: ;
    endcase
    for (int r = 0; r < 3; r++) begin
      if (n < hi[r] - lo[r] + 1) return (n + lo[r]) & 'hff;
      n -= hi[r] - lo[r] + 1;
    end
    return -1;
  endfunction

  task automatic take_access(input logic [ModeW-1:0] m, input logic [ByteW-1:0] wb,
                             output beat_t r);
    kind_e k;
    int    act;
    int    ln;
    int    v;
    r = '0;
    case (m)
      MODE_DATA_RD: begin
        second_byte = 1'b0;
        r.read_byte = prefetch;
        prefetch    = vram[addr];
        addr        = addr + 1'b1;
      end
      MODE_DATA_WR: begin
        second_byte = 1'b0;
        if (code == CODE_COLOUR) cram[addr[4:0]] = wb;
        else vram[addr] = wb;
        addr = addr + 1'b1;
      end
      MODE_CTRL_WR: begin
        if (!second_byte) begin
          second_byte = 1'b1;
          addr[7:0]   = wb;
        end else begin
          second_byte = 1'b0;
          addr[13:8]  = wb[5:0];
          code        = wb[7:6];
          if (code == CODE_READ) begin
            prefetch = vram[addr];
            addr     = addr + 1'b1;
          end else if (code == CODE_REG && wb[3:0] <= REG_LINE) begin
            regs[wb[3:0]] = addr[7:0];
          end
        end
      end
      MODE_STATUS: begin
        second_byte = 1'b0;
        r.read_byte = status;
        status      = '0;
        line_flag   = 1'b0;
      end
      MODE_TICK: begin
        k = kind_of();
        if (k != KIND_NONE) begin
          act = (k == KIND_224) ? 224 : (k == KIND_240) ? 240 : 192;
          ln  = int'(scan);
          if (ln == act + 1) status[7] = 1'b1;
          if (ln <= act) begin
            line_ctr = line_ctr - 1'b1;
            if (line_ctr == 8'hff) begin
              line_ctr  = regs[REG_LINE];
              line_flag = 1'b1;
            end
          end else begin
            line_ctr = regs[REG_LINE];
          end
          ln   = (ln + 1) % (std50 ? 313 : 262);
          scan = ln[LineW-1:0];
          v    = map_line(std50, k, ln);
          if (v >= 0) vcount = v[7:0];
        end
      end
      default: ;
    endcase
    r.irq    = (regs[REG_CTRL1][5] & status[7]) | (regs[REG_CTRL0][4] & line_flag);
    r.vcount = vcount;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < VramDepth; i++) vram[i] = '0;
      for (int i = 0; i < 32; i++) cram[i] = '0;
      for (int i = 0; i < 11; i++) regs[i] = '0;
      addr        = '0;
      code        = CODE_READ;
      prefetch    = '0;
      status      = '0;
      line_flag   = 1'b0;
      line_ctr    = '0;
      second_byte = 1'b0;
      scan        = '0;
      vcount      = '0;
      std50       = 1'b0;
      errors      = 0;
      beats_due.delete();
      errors_o <= 0;
      due_o    <= 0;
      line_o   <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.read_byte = out_i.read_byte;
        got.irq       = out_i.interrupt_request;
        got.vcount    = out_i.vertical_count;
        if (beats_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: read_byte %02h irq %0b vertical_count %02h",
                     got.read_byte, got.irq, got.vcount);
        end else begin
          want = beats_due.pop_front();
          if (got.read_byte !== want.read_byte || got.irq !== want.irq ||
              got.vcount !== want.vcount) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch (expected/actual): read_byte %02h/%02h irq %0b/%0b %s",
                       want.read_byte, got.read_byte, want.irq, got.irq,
                       $sformatf("vertical_count %02h/%02h", want.vcount, got.vcount));
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) std50 = cfg_i.video_standard;
      if (in_i.valid && in_i.ready) begin
        take_access(in_i.mode, in_i.write_byte, want);
        beats_due.push_back(want);
      end
      errors_o <= errors;
      due_o    <= beats_due.size();
      line_o   <= int'(scan);
    end
  end

endmodule

[tb/video_port_and_line_timer_top_tb.sv]
// Testbench top of the video port and line timer: clock, reset, port access
// stimulus in four phases of input idling and output stalls, and the verdict.
// Depends on vpt_pkg, vpt_if, the block's top level and vpt_result_checker.
module video_port_and_line_timer_top_tb;
  import vpt_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 8;
  localparam int PhaseItems = 250;
  localparam logic [ModeW-1:0] MODE_SPARE = 3'd5;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   results_due;
  int   line_hint;
  int   cycles = 0;
  int   idle_pct;
  int   stall_pct;
  int   random_items;
  bit   hold_request;

  vpt_in_if  in_ch ();
  vpt_out_if out_ch ();
  vpt_cfg_if cfg_ch ();

  video_port_and_line_timer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  vpt_result_checker results_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_ch),
    .out_i    (out_ch),
    .cfg_i    (cfg_ch),
    .errors_o (errors),
    .due_o    (results_due),
    .line_o   (line_hint)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic put_item(input logic [ModeW-1:0] m, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.write_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    if (m <= MODE_TICK) random_items++;
  endtask

  task automatic reg_write(input logic [3:0] idx, input logic [ByteW-1:0] value);
    logic [1:0] hi_bits;
    hi_bits = 2'($urandom);
    put_item(MODE_CTRL_WR, value);
    put_item(MODE_CTRL_WR, {CODE_REG, hi_bits, idx});
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_standard(input logic s);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.video_standard <= s;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_burst();
    int         pick;
    int         len;
    logic [3:0] m;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [1:0] code;
    logic [5:0] hi_addr;
    pick = $urandom_range(99);
    if (pick < 30) begin
      len = $urandom_range(40, 1);
      repeat (len) put_item(MODE_TICK, 8'($urandom));
    end else if (pick < 42) begin
      case ($urandom_range(7))
        0: m = 4'h2;
        1: m = 4'h8;
        2: m = 4'ha;
        3: m = 4'hc;
        4: m = 4'hf;
        5: m = 4'hb;
        6: m = 4'he;
        default: m = 4'($urandom);
      endcase
      r0    = 8'($urandom);
      r1    = 8'($urandom);
      r0[1] = m[1];
      r0[2] = m[3];
      r1[4] = m[0];
      r1[3] = m[2];
      reg_write(REG_CTRL0, r0);
      reg_write(REG_CTRL1, r1);
    end else if (pick < 50) begin
      if ($urandom_range(1)) reg_write(REG_LINE, 8'($urandom_range(5)));
      else reg_write(4'($urandom), 8'($urandom));
    end else if (pick < 68) begin
      case ($urandom_range(2))
        0: code = CODE_READ;
        1: code = CODE_COLOUR;
        default: code = 2'd1;
      endcase
      hi_addr = ($urandom_range(3) == 0) ? 6'($urandom) : '0;
      put_item(MODE_CTRL_WR,
               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(63)));
      put_item(MODE_CTRL_WR, {code, hi_addr});
      len = $urandom_range(6, 1);
      repeat (len) put_item($urandom_range(1) ? MODE_DATA_WR : MODE_DATA_RD, 8'($urandom));
    end else if (pick < 78) begin
      put_item(MODE_STATUS, 8'($urandom));
    end else if (pick < 88) begin
      put_item($urandom_range(1) ? MODE_DATA_WR : MODE_DATA_RD, 8'($urandom));
    end else begin
      put_item(3'($urandom_range(7)), 8'($urandom));
    end
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 83, 0, 27};
    phase_stall = '{0, 0, 83, 27};
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_DATA_RD;
    in_ch.write_byte      = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.video_standard = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    hold_request          = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_standard(1'b0);

    put_item(MODE_STATUS, 8'h00);
    put_item(MODE_DATA_RD, 8'hff);
    put_item(MODE_CTRL_WR, 8'hff);
    put_item(MODE_CTRL_WR, 8'h7f);
    put_item(MODE_DATA_WR, 8'haa);
    put_item(MODE_CTRL_WR, 8'hff);
    put_item(MODE_CTRL_WR, 8'h3f);
    put_item(MODE_DATA_RD, 8'h00);
    put_item(MODE_CTRL_WR, 8'h1f);
    put_item(MODE_CTRL_WR, 8'hc0);
    put_item(MODE_DATA_WR, 8'h55);
    put_item(MODE_DATA_WR, 8'h00);
    reg_write(4'hf, 8'hff);
    reg_write(REG_CTRL0, 8'h16);
    reg_write(REG_CTRL1, 8'h38);
    reg_write(REG_LINE, 8'h00);
    put_item(MODE_DATA_WR, 8'h77);
    put_item(MODE_CTRL_WR, 8'h12);
    put_item(MODE_STATUS, 8'h00);
    repeat (3) put_item(MODE_TICK, 8'h00);
    put_item(MODE_SPARE, 8'hff);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 1) begin
        // Leave the 313-line frame past line 262 so that the shorter frame
        // has to wrap the scan line.
        reg_write(REG_CTRL0, 8'h04);
        reg_write(REG_CTRL1, 8'h00);
        while (line_hint < 270) begin
          put_item(MODE_TICK, 8'($urandom));
          wait_drained();
        end
        wait_drained();
      end
      write_standard(ph[0] ? 1'b0 : 1'b1);
      if (ph == 0) hold_request = 1'b1;
      random_items = 0;
      while (random_items < PhaseItems) random_burst();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
